// File: rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int CP_WIDTH    = 21;
   localparam int UNIT_WIDTH  = 16;
   localparam int BYTE_WIDTH  = 8;
   localparam int CAP_WIDTH   = 24;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // request and result codes
   localparam logic REQ_BYTE        = 1'b0;
   localparam logic REQ_END         = 1'b1;
   localparam logic RES_UNIT        = 1'b0;
   localparam logic RES_SUMMARY     = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_QUERY   = 1'b1;

   // code point constants
   localparam logic [UNIT_WIDTH-1:0] REPL_CHAR    = 16'hFFFD;
   localparam logic [UNIT_WIDTH-1:0] SURR_HI_BASE = 16'hD800;
   localparam logic [UNIT_WIDTH-1:0] SURR_LO_BASE = 16'hDC00;
   localparam logic [UNIT_WIDTH-1:0] TEN_BIT_MASK = 16'h03FF;
   localparam logic [CP_WIDTH-1:0]   MIN_CP_2     = 21'h00080;
   localparam logic [CP_WIDTH-1:0]   MIN_CP_3     = 21'h00800;
   localparam logic [CP_WIDTH-1:0]   SUPP_BASE    = 21'h10000;
   localparam logic [CP_WIDTH-1:0]   MAX_CP       = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0]   SURR_FIRST   = 21'h0D800;
   localparam logic [CP_WIDTH-1:0]   SURR_LAST    = 21'h0DFFF;

   // byte classification masks and tags
   localparam logic [BYTE_WIDTH-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] CONT_TAG   = 8'h80;
   localparam logic [BYTE_WIDTH-1:0] PAYLOAD6   = 8'h3F;
   localparam logic [BYTE_WIDTH-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_WIDTH-1:0] LEAD2_TAG  = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_WIDTH-1:0] LEAD3_TAG  = 8'hE0;
   localparam logic [BYTE_WIDTH-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_WIDTH-1:0] LEAD4_TAG  = 8'hF0;

   // one queue entry per accepted request: up to two code points, then
   // optionally the end summary
   typedef struct packed {
      logic                  is_end;
      logic                  a_valid;
      logic [CP_WIDTH-1:0]   a_cp;
      logic                  a_rep;
      logic                  b_valid;
      logic [UNIT_WIDTH-1:0] b_cp;
      logic                  b_rep;
   } u8u16_entry_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_LOW,
      PH_SECOND,
      PH_SUMMARY
   } u8u16_phase_type;

   typedef enum logic [2:0] {
      ST_NONE,
      ST_FIRST,
      ST_LOW,
      ST_SECOND,
      ST_SUMMARY
   } u8u16_step_type;

endpackage

// File: rtl/core/u8u16_if.sv
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Request (source byte / end) and response (unit / summary) channels.
// ----------------------------------------------------------------------------
interface u8u16_req_if;
   import u8u16_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [BYTE_WIDTH-1:0] in_byte;

   modport source (output valid, output req_type, output in_byte, input ready);
   modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface u8u16_rsp_if;
   import u8u16_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [UNIT_WIDTH-1:0] code_unit;
   logic                  replaced;
   logic [CAP_WIDTH-1:0]  written_bytes;
   logic                  status;
   logic                  last_result;

   modport source (output valid, output result_kind, output code_unit, output replaced,
                   output written_bytes, output status, output last_result,
                   input ready);
   modport sink   (input valid, input result_kind, input code_unit, input replaced,
                   input written_bytes, input status, input last_result,
                   output ready);
endinterface

// File: rtl/core/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// UTF-8 sequence decoder: classifies each byte and queues code points.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic                       clock,
   input  logic                       reset,
   u8u16_req_if.sink                  req_ch,
   input  logic                       queue_full,
   output logic                       push,
   output u8u16_pkg::u8u16_entry_type push_data
);
   import u8u16_pkg::*;

   logic [CP_WIDTH-1:0]   acc_ff, acc_in;
   logic [1:0]            rem_ff, rem_in;
   logic [1:0]            len_ff, len_in;
   logic [BYTE_WIDTH-1:0] src_byte;
   logic                  is_cont;
   logic [CP_WIDTH-1:0]   acc_cont;
   logic                  bad_cp;
   logic                  ld_emit;
   logic [UNIT_WIDTH-1:0] ld_cp;
   logic                  ld_rep;
   logic                  ld_start;
   logic [CP_WIDTH-1:0]   ld_acc;
   logic [1:0]            ld_len;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;
   assign src_byte     = req_ch.in_byte;
   assign is_cont      = (src_byte & CONT_MASK) == CONT_TAG;
   assign acc_cont     = {acc_ff[CP_WIDTH-7:0], src_byte[5:0] & PAYLOAD6[5:0]};

   // overlong, surrogate or out of range
   assign bad_cp = (len_ff == 2'd1 && acc_cont < MIN_CP_2) ||
                   (len_ff == 2'd2 && acc_cont < MIN_CP_3) ||
                   (len_ff == 2'd3 && acc_cont < SUPP_BASE) ||
                   (acc_cont > MAX_CP) ||
                   (acc_cont >= SURR_FIRST && acc_cont <= SURR_LAST);

   // lead byte decode
   always_comb begin
      ld_emit  = 1'b0;
      ld_cp    = REPL_CHAR;
      ld_rep   = 1'b0;
      ld_start = 1'b0;
      ld_acc   = '0;
      ld_len   = 2'd0;
      if (!src_byte[7]) begin
         ld_emit = 1'b1;
         ld_cp   = UNIT_WIDTH'(src_byte);
      end else if ((src_byte & LEAD2_MASK) == LEAD2_TAG) begin
         ld_start = 1'b1;
         ld_acc   = CP_WIDTH'(src_byte[4:0]);
         ld_len   = 2'd1;
      end else if ((src_byte & LEAD3_MASK) == LEAD3_TAG) begin
         ld_start = 1'b1;
         ld_acc   = CP_WIDTH'(src_byte[3:0]);
         ld_len   = 2'd2;
      end else if ((src_byte & LEAD4_MASK) == LEAD4_TAG) begin
         ld_start = 1'b1;
         ld_acc   = CP_WIDTH'(src_byte[2:0]);
         ld_len   = 2'd3;
      end else begin
         ld_emit = 1'b1;
         ld_rep  = 1'b1;
      end
   end

   always_comb begin
      push_data = '0;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      len_in    = len_ff;
      if (req_ch.req_type == REQ_END) begin
         // truncated sequence at end of source
         push_data.is_end  = 1'b1;
         push_data.a_valid = (rem_ff != 2'd0);
         push_data.a_cp    = CP_WIDTH'(REPL_CHAR);
         push_data.a_rep   = 1'b1;
         acc_in            = '0;
         rem_in            = 2'd0;
         len_in            = 2'd0;
      end else if (rem_ff != 2'd0 && is_cont) begin
         acc_in = acc_cont;
         rem_in = rem_ff - 2'd1;
         if (rem_ff == 2'd1) begin
            push_data.a_valid = 1'b1;
            push_data.a_cp    = bad_cp ? CP_WIDTH'(REPL_CHAR) : acc_cont;
            push_data.a_rep   = bad_cp;
         end
      end else if (rem_ff != 2'd0) begin
         // broken sequence: replace it, then take the byte as a new lead
         push_data.a_valid = 1'b1;
         push_data.a_cp    = CP_WIDTH'(REPL_CHAR);
         push_data.a_rep   = 1'b1;
         push_data.b_valid = ld_emit;
         push_data.b_cp    = ld_cp;
         push_data.b_rep   = ld_rep;
         rem_in            = 2'd0;
         if (ld_start) begin
            acc_in = ld_acc;
            rem_in = ld_len;
            len_in = ld_len;
         end
      end else begin
         push_data.a_valid = ld_emit;
         push_data.a_cp    = CP_WIDTH'(ld_cp);
         push_data.a_rep   = ld_rep;
         if (ld_start) begin
            acc_in = ld_acc;
            rem_in = ld_len;
            len_in = ld_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= 2'd0;
         len_ff <= 2'd0;
      end else if (push) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         len_ff <= len_in;
      end
   end

   a_rem_within_len: assert property (@(posedge clock) disable iff (reset)
      rem_ff != 2'd0 |-> len_ff != 2'd0 && rem_ff <= len_ff)
      else $error("pending count exceeds sequence length");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      push && req_ch.req_type == REQ_END |=> rem_ff == 2'd0 && acc_ff == '0)
      else $error("decoder state not cleared after end of source");

   a_cont_no_second: assert property (@(posedge clock) disable iff (reset)
      push && rem_ff != 2'd0 && is_cont |-> !push_data.b_valid)
      else $error("continuation byte produced a second code point");

endmodule

// File: rtl/core/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Short FIFO of decoded entries between decoder and emitter.
// ----------------------------------------------------------------------------
module u8u16_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  u8u16_pkg::u8u16_entry_type push_data,
   output logic                       full,
   output logic                       head_valid,
   output u8u16_pkg::u8u16_entry_type head_data,
   input  logic                       pop
);
   import u8u16_pkg::*;

   u8u16_entry_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   level_ff, level_in;

   assign full       = (level_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (level_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign level_in   = level_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         level_ff <= level_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue level out of range");

endmodule

// File: rtl/core/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Emitter: capacity check, byte count, surrogate split and result register.
// ----------------------------------------------------------------------------
module u8u16_back #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  u8u16_pkg::u8u16_entry_type         head_data,
   output logic                               pop,
   input  logic [u8u16_pkg::CAP_WIDTH-1:0]    out_capacity,
   input  logic                               size_query,
   u8u16_rsp_if.source                        rsp_ch
);
   import u8u16_pkg::*;

   localparam int CMP_W = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;

   typedef struct packed {
      logic                  result_kind;
      logic [UNIT_WIDTH-1:0] code_unit;
      logic                  replaced;
      logic [CAP_WIDTH-1:0]  written_bytes;
      logic                  status;
      logic                  last_result;
   } result_type;

   u8u16_phase_type        phase_ff, phase_in;
   u8u16_step_type         step;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   result_type             out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   logic                   step_go;
   logic [CMP_W-1:0]       cap_x, sum2, sum4;
   logic [COUNT_WIDTH-1:0] sat2, sat4;
   logic                   fits2, fits4;
   logic                   a_supp, a_emit, b_emit, b_next;
   logic [CP_WIDTH-1:0]    supp_off;
   logic [UNIT_WIDTH-1:0]  hi_unit, lo_unit;
   logic [CMP_W-1:0]       count_x;
   logic                   load;
   result_type             res;

   assign step_go  = head_valid && (!out_valid_ff || rsp_ch.ready);
   assign cap_x    = CMP_W'(out_capacity);
   assign count_x  = CMP_W'(count_ff);
   assign sum2     = count_x + CMP_W'(2);
   assign sum4     = count_x + CMP_W'(4);
   assign sat2     = (|sum2[CMP_W-1:COUNT_WIDTH]) ? '1 : sum2[COUNT_WIDTH-1:0];
   assign sat4     = (|sum4[CMP_W-1:COUNT_WIDTH]) ? '1 : sum4[COUNT_WIDTH-1:0];
   assign fits2    = !(sum2 > cap_x);
   assign fits4    = !(sum4 > cap_x);

   assign a_supp   = (head_data.a_cp >= SUPP_BASE);
   assign a_emit   = !ovf_ff && !size_query && (a_supp ? fits4 : fits2);
   assign b_emit   = !ovf_ff && !size_query && fits2;
   // after one more unit, will the second code point still be emitted
   assign b_next   = head_data.b_valid && fits4;

   assign supp_off = head_data.a_cp - SUPP_BASE;
   assign hi_unit  = SURR_HI_BASE + (UNIT_WIDTH'(supp_off[19:10]) & TEN_BIT_MASK);
   assign lo_unit  = SURR_LO_BASE + (UNIT_WIDTH'(supp_off[9:0]) & TEN_BIT_MASK);

   // current step decoder
   always_comb begin
      unique case (phase_ff)
         PH_FIRST: begin
            if (head_data.a_valid) begin
               step = ST_FIRST;
            end else if (head_data.b_valid) begin
               step = ST_SECOND;
            end else if (head_data.is_end) begin
               step = ST_SUMMARY;
            end else begin
               step = ST_NONE;
            end
         end
         PH_LOW:     step = ST_LOW;
         PH_SECOND:  step = ST_SECOND;
         PH_SUMMARY: step = ST_SUMMARY;
         default:    step = ST_NONE;
      endcase
   end

   // next phase and queue pop
   always_comb begin
      phase_in = phase_ff;
      pop      = 1'b0;
      if (step_go) begin
         unique case (step)
            ST_FIRST, ST_LOW: begin
               if (step == ST_FIRST && a_emit && a_supp) begin
                  phase_in = PH_LOW;
               end else if (head_data.b_valid) begin
                  phase_in = PH_SECOND;
               end else if (head_data.is_end) begin
                  phase_in = PH_SUMMARY;
               end else begin
                  phase_in = PH_FIRST;
                  pop      = 1'b1;
               end
            end
            ST_SECOND: begin
               if (head_data.is_end) begin
                  phase_in = PH_SUMMARY;
               end else begin
                  phase_in = PH_FIRST;
                  pop      = 1'b1;
               end
            end
            default: begin
               phase_in = PH_FIRST;
               pop      = 1'b1;
            end
         endcase
      end
   end

   // count, overflow and result for the current step
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      load     = 1'b0;
      res      = '0;
      if (step_go) begin
         unique case (step)
            ST_FIRST: begin
               if (ovf_ff) begin
                  count_in = count_ff;
               end else if (size_query) begin
                  count_in = a_supp ? sat4 : sat2;
               end else if (!a_emit) begin
                  ovf_in = 1'b1;
               end else begin
                  load              = 1'b1;
                  count_in          = sat2;
                  res.result_kind   = RES_UNIT;
                  res.code_unit     = a_supp ? hi_unit : head_data.a_cp[UNIT_WIDTH-1:0];
                  res.replaced      = head_data.a_rep;
                  res.written_bytes = CAP_WIDTH'(CMP_W'(sat2));
                  res.status        = STATUS_OK;
                  res.last_result   = !a_supp && !(b_next || head_data.is_end);
               end
            end
            ST_LOW: begin
               load              = 1'b1;
               count_in          = sat2;
               res.result_kind   = RES_UNIT;
               res.code_unit     = lo_unit;
               res.replaced      = head_data.a_rep;
               res.written_bytes = CAP_WIDTH'(CMP_W'(sat2));
               res.status        = STATUS_OK;
               res.last_result   = !(b_next || head_data.is_end);
            end
            ST_SECOND: begin
               if (ovf_ff) begin
                  count_in = count_ff;
               end else if (size_query) begin
                  count_in = sat2;
               end else if (!b_emit) begin
                  ovf_in = 1'b1;
               end else begin
                  load              = 1'b1;
                  count_in          = sat2;
                  res.result_kind   = RES_UNIT;
                  res.code_unit     = head_data.b_cp;
                  res.replaced      = head_data.b_rep;
                  res.written_bytes = CAP_WIDTH'(CMP_W'(sat2));
                  res.status        = STATUS_OK;
                  res.last_result   = !head_data.is_end;
               end
            end
            ST_SUMMARY: begin
               load              = 1'b1;
               res.result_kind   = RES_SUMMARY;
               res.written_bytes = CAP_WIDTH'(count_x);
               res.status        = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
               res.last_result   = 1'b1;
               count_in          = '0;
               ovf_in            = 1'b0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      if (step_go) begin
         out_valid_in = load;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ch.ready;
      end
      out_in = load ? res : out_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.result_kind   = out_ff.result_kind;
   assign rsp_ch.code_unit     = out_ff.code_unit;
   assign rsp_ch.replaced      = out_ff.replaced;
   assign rsp_ch.written_bytes = out_ff.written_bytes;
   assign rsp_ch.status        = out_ff.status;
   assign rsp_ch.last_result   = out_ff.last_result;

   a_low_after_high: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LOW |-> out_valid_ff && out_ff.code_unit[15:10] == SURR_HI_BASE[15:10])
      else $error("low surrogate phase without pending high surrogate");

   a_unit_status_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.result_kind == RES_UNIT |-> out_ff.status == STATUS_OK)
      else $error("code unit carries overflow status");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.result_kind == RES_SUMMARY |-> out_ff.last_result)
      else $error("summary not marked last");

   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      step_go && step == ST_SUMMARY |=> count_ff == '0 && !ovf_ff)
      else $error("stream count not cleared after summary");

endmodule

// File: rtl/core/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// UTF-8 byte stream in, UTF-16 code units and an end summary out.
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer carries
//  -------   ---------  -----------------------------------------------------
//  req_ch    in         req_type, in_byte (one source byte or end of source)
//  rsp_ch    out        result_kind, code_unit, replaced, written_bytes,
//                       status, last_result
//  csr_*     in         write enable, register index, 24-bit write data
//
//  One source byte is taken per cycle while the queue is not full. The
//  emitter takes one step per result and one per queued entry that yields
//  none, so a byte giving two results (surrogate pair, or a replacement
//  followed by a new lead) puts it behind; a four-entry queue absorbs that.
//  Reset is synchronous and clears the stream state and both registers.
//  A response stall fills the result register, then the queue, then drops
//  req_ch.ready; a request stall leaves the emitter draining the queue.
//
module utf8_to_utf16_transcoder_core #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   u8u16_req_if.sink                           req_ch,
   u8u16_rsp_if.source                         rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [u8u16_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [u8u16_pkg::CAP_WIDTH-1:0]     csr_wdata
);
   import u8u16_pkg::*;

   // configuration registers
   logic [CAP_WIDTH-1:0] cap_ff, cap_in;
   logic                 sq_ff, sq_in;

   // decoder to queue, queue to emitter
   logic            push;
   u8u16_entry_type push_data;
   logic            queue_full;
   logic            head_valid;
   u8u16_entry_type head_data;
   logic            pop;

   // decode the register index on each write
   always_comb begin
      cap_in = cap_ff;
      sq_in  = sq_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OUT_CAPACITY: cap_in = csr_wdata;
            CSR_SIZE_QUERY:   sq_in  = csr_wdata[0];
            default:          cap_in = cap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
         sq_ff  <= 1'b0;
      end else begin
         cap_ff <= cap_in;
         sq_ff  <= sq_in;
      end
   end

   // front: classify bytes, assemble sequences, queue code points
   u8u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decouple the two halves so each can stall on its own
   u8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // back: count against capacity, split surrogates, hold the result
   u8u16_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop          (pop),
      .out_capacity (cap_ff),
      .size_query   (sq_ff),
      .rsp_ch       (rsp_ch)
   );

endmodule
